@@ rtl/sns_pkg.sv @@
// Shared types and constants of the SPI NOR flash command sequencer.
// Used by the front end, the job queue, the back end and the top level.
package sns_pkg;

    // payload widths
    localparam int ACT_W  = 3;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;

    // flash geometry
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_W       = $clog2(PAGE_BYTES);
    localparam int ROOM_W       = PAGE_W + 1;
    localparam int SECT_SHIFT   = $clog2(SECTOR_BYTES);

    // job queue and back end sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W      = 3;

    // request codes
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WDATA      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REPLY      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SECT_ERASE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CHIP_ERASE = 3'd5;

    // flash opcodes
    localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_RDSR1 = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_PP    = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_SE    = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_CE    = 8'hC7;
    localparam logic [BYTE_W-1:0] DUMMY     = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READ,
        PH_WDATA,
        PH_POLL_PROG,
        PH_POLL_PRE,
        PH_ERASE_ACK,
        PH_POLL_POST
    } t_phase;

    typedef enum logic [1:0] {
        OP_READ,
        OP_PROG,
        OP_SECT,
        OP_CHIP
    } t_op;

    // byte sequences the back end knows how to emit
    typedef enum logic [3:0] {
        J_ERR,       // phase error marker
        J_DONE,      // completion marker only
        J_RSTART,    // read opcode, address, first dummy
        J_RREPLY,    // read data, maybe next dummy
        J_PAGE,      // write enable, program opcode, address
        J_BYTE,      // one data byte
        J_CMD_POLL,  // one byte with cs release, then status poll
        J_POLL,      // status poll
        J_SECT       // sector erase opcode and address
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic               four_byte;
        logic               flag_a;  // zero length / done
        logic               flag_b;  // release after next dummy
    } t_job;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_byte;
        logic              spi_valid;
        logic              cs_release;
        logic              expect_reply;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic              op_done;
        logic              phase_error;
        logic              last;
    } t_result;

endpackage

@@ rtl/sns_front.sv @@
// Front end: accepts request transactions, tracks the flash phase and turns
// each request into one job for the back end. Depends on sns_pkg.
module sns_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           i_accept,
    input  logic [sns_pkg::ACT_W-1:0]      i_action,
    input  logic [sns_pkg::ADDR_W-1:0]     i_address,
    input  logic [sns_pkg::CNT_W-1:0]      i_byte_count,
    input  logic [sns_pkg::BYTE_W-1:0]     i_value,
    output sns_pkg::t_job                  o_job
);

    sns_pkg::t_phase                  r_phase, n_phase;
    sns_pkg::t_op                     r_op, n_op;
    logic [sns_pkg::ADDR_W-1:0]       r_cur, n_cur;
    logic [sns_pkg::CNT_W-1:0]        r_bytes, n_bytes;
    logic [sns_pkg::ROOM_W-1:0]       r_chunk, n_chunk;
    logic                             r_four;

    logic [sns_pkg::ADDR_W-1:0]       pg_addr;
    logic [sns_pkg::CNT_W-1:0]        pg_cnt;
    logic [sns_pkg::ROOM_W-1:0]       room;
    logic [sns_pkg::ROOM_W-1:0]       pg_chunk;
    logic [sns_pkg::CNT_W-1:0]        bytes_dec;
    logic [sns_pkg::ROOM_W-1:0]       chunk_dec;

    // address width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_four <= i_cfg_wr_data;
        end
    end

    // request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sns_pkg::PH_IDLE;
            r_op    <= sns_pkg::OP_READ;
            r_cur   <= '0;
            r_bytes <= '0;
            r_chunk <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_cur   <= n_cur;
            r_bytes <= n_bytes;
            r_chunk <= n_chunk;
        end
    end

    // bytes left in the page the next program starts in
    always_comb begin
        pg_addr  = (r_phase == sns_pkg::PH_IDLE) ? i_address : r_cur;
        pg_cnt   = (r_phase == sns_pkg::PH_IDLE) ? i_byte_count : r_bytes;
        room     = sns_pkg::ROOM_W'(sns_pkg::PAGE_BYTES)
                   - {1'b0, pg_addr[sns_pkg::PAGE_W-1:0]};
        pg_chunk = (pg_cnt < {{(sns_pkg::CNT_W - sns_pkg::ROOM_W){1'b0}}, room})
                   ? pg_cnt[sns_pkg::ROOM_W-1:0] : room;
        bytes_dec = r_bytes - sns_pkg::CNT_W'(1);
        chunk_dec = r_chunk - sns_pkg::ROOM_W'(1);
    end

    // classify the transaction against the phase, next state and job
    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_cur   = r_cur;
        n_bytes = r_bytes;
        n_chunk = r_chunk;
        o_job           = '0;
        o_job.kind      = sns_pkg::J_ERR;
        o_job.four_byte = r_four;
        case (r_phase)
            sns_pkg::PH_IDLE: begin
                if (i_action == sns_pkg::ACT_READ) begin
                    n_op         = sns_pkg::OP_READ;
                    n_cur        = i_address;
                    n_bytes      = i_byte_count;
                    o_job.kind   = sns_pkg::J_RSTART;
                    o_job.addr   = i_address;
                    o_job.flag_a = (i_byte_count == '0);
                    o_job.flag_b = (i_byte_count == sns_pkg::CNT_W'(1));
                    if (i_byte_count != '0) begin
                        n_phase = sns_pkg::PH_READ;
                    end
                end else if (i_action == sns_pkg::ACT_WRITE) begin
                    n_op    = sns_pkg::OP_PROG;
                    n_cur   = i_address;
                    n_bytes = i_byte_count;
                    if (i_byte_count == '0) begin
                        o_job.kind = sns_pkg::J_DONE;
                    end else begin
                        n_chunk    = pg_chunk;
                        o_job.kind = sns_pkg::J_PAGE;
                        o_job.addr = i_address;
                        n_phase    = sns_pkg::PH_WDATA;
                    end
                end else if (i_action == sns_pkg::ACT_SECT_ERASE ||
                             i_action == sns_pkg::ACT_CHIP_ERASE) begin
                    if (i_action == sns_pkg::ACT_SECT_ERASE) begin
                        n_op  = sns_pkg::OP_SECT;
                        n_cur = i_address << sns_pkg::SECT_SHIFT;
                    end else begin
                        n_op  = sns_pkg::OP_CHIP;
                        n_cur = '0;
                    end
                    o_job.kind = sns_pkg::J_CMD_POLL;
                    o_job.data = sns_pkg::CMD_WREN;
                    n_phase    = sns_pkg::PH_POLL_PRE;
                end
            end
            sns_pkg::PH_READ: begin
                if (i_action == sns_pkg::ACT_REPLY) begin
                    n_bytes      = bytes_dec;
                    o_job.kind   = sns_pkg::J_RREPLY;
                    o_job.data   = i_value;
                    o_job.flag_a = (bytes_dec == '0);
                    o_job.flag_b = (bytes_dec == sns_pkg::CNT_W'(1));
                    if (bytes_dec == '0) begin
                        n_phase = sns_pkg::PH_IDLE;
                    end
                end
            end
            sns_pkg::PH_WDATA: begin
                if (i_action == sns_pkg::ACT_WDATA) begin
                    n_cur      = r_cur + sns_pkg::ADDR_W'(1);
                    n_bytes    = bytes_dec;
                    n_chunk    = chunk_dec;
                    o_job.data = i_value;
                    if (chunk_dec == '0) begin
                        o_job.kind = sns_pkg::J_CMD_POLL;
                        n_phase    = sns_pkg::PH_POLL_PROG;
                    end else begin
                        o_job.kind = sns_pkg::J_BYTE;
                    end
                end
            end
            default: begin
                // polling phases, driven by status replies
                if (i_action == sns_pkg::ACT_REPLY) begin
                    if (r_phase == sns_pkg::PH_ERASE_ACK) begin
                        o_job.kind = sns_pkg::J_POLL;
                        n_phase    = sns_pkg::PH_POLL_POST;
                    end else if (i_value[0]) begin
                        o_job.kind = sns_pkg::J_POLL;
                    end else if (r_phase == sns_pkg::PH_POLL_PROG) begin
                        if (r_bytes != '0) begin
                            n_chunk    = pg_chunk;
                            o_job.kind = sns_pkg::J_PAGE;
                            o_job.addr = r_cur;
                            n_phase    = sns_pkg::PH_WDATA;
                        end else begin
                            o_job.kind = sns_pkg::J_DONE;
                            n_phase    = sns_pkg::PH_IDLE;
                        end
                    end else if (r_phase == sns_pkg::PH_POLL_PRE) begin
                        if (r_op == sns_pkg::OP_CHIP) begin
                            o_job.kind = sns_pkg::J_CMD_POLL;
                            o_job.data = sns_pkg::CMD_CE;
                            n_phase    = sns_pkg::PH_POLL_POST;
                        end else begin
                            o_job.kind = sns_pkg::J_SECT;
                            o_job.addr = r_cur;
                            n_phase    = sns_pkg::PH_ERASE_ACK;
                        end
                    end else begin
                        o_job.kind = sns_pkg::J_DONE;
                        n_phase    = sns_pkg::PH_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/sns_job_fifo.sv @@
// Short job queue between the front end and the back end, first-word
// fall-through. Depends on sns_pkg.
module sns_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sns_pkg::t_job  i_job,
    input  logic           i_pop,
    output sns_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);

    sns_pkg::t_job                 r_mem [sns_pkg::QUEUE_DEPTH];
    logic [sns_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sns_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sns_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == sns_pkg::QCNT_W'(sns_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + sns_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + sns_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + sns_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - sns_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/sns_back.sv @@
// Back end: steps through the head job one result per cycle while the output
// is not stalled, into the output register. Depends on sns_pkg.
module sns_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sns_pkg::t_job     i_job,
    input  logic              i_empty,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_valid,
    output sns_pkg::t_result  o_result
);

    logic [sns_pkg::STEP_W-1:0]   r_step;
    logic                         r_valid;
    sns_pkg::t_result             r_result;
    sns_pkg::t_result             res;
    logic                         out_free;
    logic [sns_pkg::STEP_W-1:0]   step_m1;
    logic [sns_pkg::STEP_W-1:0]   step_m2;
    logic [sns_pkg::STEP_W-1:0]   addr_cnt;
    logic [1:0]                   k_last;
    logic [1:0]                   k1;
    logic [1:0]                   k2;

    // address byte k of the frame, skipping the top byte in three-byte mode
    function automatic logic [sns_pkg::BYTE_W-1:0] addr_byte(
        input logic [sns_pkg::ADDR_W-1:0] a,
        input logic                       four,
        input logic [1:0]                 k
    );
        logic [1:0] sel;
        logic [sns_pkg::BYTE_W-1:0] b;
        sel = four ? k : k + 2'd1;
        case (sel)
            2'd0:    b = a[31:24];
            2'd1:    b = a[23:16];
            2'd2:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

    assign out_free = !r_valid || !i_out_stall;
    assign o_pop    = out_free && !i_empty && res.last;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // step decode
    always_comb begin
        step_m1  = r_step - sns_pkg::STEP_W'(1);
        step_m2  = r_step - sns_pkg::STEP_W'(2);
        k1       = step_m1[1:0];
        k2       = step_m2[1:0];
        addr_cnt = i_job.four_byte ? sns_pkg::STEP_W'(4) : sns_pkg::STEP_W'(3);
        k_last   = i_job.four_byte ? 2'd3 : 2'd2;
    end

    // result of the current step of the head job
    always_comb begin
        res = '0;
        case (i_job.kind)
            sns_pkg::J_ERR: begin
                res.phase_error = 1'b1;
                res.last        = 1'b1;
            end
            sns_pkg::J_DONE: begin
                res.op_done = 1'b1;
                res.last    = 1'b1;
            end
            sns_pkg::J_RREPLY: begin
                res.read_data  = i_job.data;
                res.read_valid = 1'b1;
                res.last       = 1'b1;
                if (i_job.flag_a) begin
                    res.op_done = 1'b1;
                end else begin
                    res.spi_byte     = sns_pkg::DUMMY;
                    res.spi_valid    = 1'b1;
                    res.expect_reply = 1'b1;
                    res.cs_release   = i_job.flag_b;
                end
            end
            sns_pkg::J_RSTART: begin
                res.spi_valid = 1'b1;
                if (r_step == '0) begin
                    res.spi_byte = sns_pkg::CMD_READ;
                end else if (r_step <= addr_cnt) begin
                    res.spi_byte = addr_byte(i_job.addr, i_job.four_byte, k1);
                    if (k1 == k_last && i_job.flag_a) begin
                        res.cs_release = 1'b1;
                        res.op_done    = 1'b1;
                        res.last       = 1'b1;
                    end
                end else begin
                    res.spi_byte     = sns_pkg::DUMMY;
                    res.expect_reply = 1'b1;
                    res.cs_release   = i_job.flag_b;
                    res.last         = 1'b1;
                end
            end
            sns_pkg::J_PAGE: begin
                res.spi_valid = 1'b1;
                if (r_step == '0) begin
                    res.spi_byte   = sns_pkg::CMD_WREN;
                    res.cs_release = 1'b1;
                end else if (r_step == sns_pkg::STEP_W'(1)) begin
                    res.spi_byte = sns_pkg::CMD_PP;
                end else begin
                    res.spi_byte = addr_byte(i_job.addr, i_job.four_byte, k2);
                    res.last     = (k2 == k_last);
                end
            end
            sns_pkg::J_BYTE: begin
                res.spi_byte  = i_job.data;
                res.spi_valid = 1'b1;
                res.last      = 1'b1;
            end
            sns_pkg::J_CMD_POLL: begin
                res.spi_valid = 1'b1;
                if (r_step == '0) begin
                    res.spi_byte   = i_job.data;
                    res.cs_release = 1'b1;
                end else if (r_step == sns_pkg::STEP_W'(1)) begin
                    res.spi_byte = sns_pkg::CMD_RDSR1;
                end else begin
                    res.spi_byte     = sns_pkg::DUMMY;
                    res.expect_reply = 1'b1;
                    res.cs_release   = 1'b1;
                    res.last         = 1'b1;
                end
            end
            sns_pkg::J_POLL: begin
                res.spi_valid = 1'b1;
                if (r_step == '0) begin
                    res.spi_byte = sns_pkg::CMD_RDSR1;
                end else begin
                    res.spi_byte     = sns_pkg::DUMMY;
                    res.expect_reply = 1'b1;
                    res.cs_release   = 1'b1;
                    res.last         = 1'b1;
                end
            end
            sns_pkg::J_SECT: begin
                res.spi_valid = 1'b1;
                if (r_step == '0) begin
                    res.spi_byte = sns_pkg::CMD_SE;
                end else begin
                    res.spi_byte = addr_byte(i_job.addr, i_job.four_byte, k1);
                    if (k1 == k_last) begin
                        res.cs_release   = 1'b1;
                        res.expect_reply = 1'b1;
                        res.last         = 1'b1;
                    end
                end
            end
            default: begin
                res.phase_error = 1'b1;
                res.last        = 1'b1;
            end
        endcase
    end

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (out_free) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_step <= res.last ? '0 : r_step + sns_pkg::STEP_W'(1);
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (out_free && !i_empty) begin
            r_result <= res;
        end
    end

endmodule

@@ rtl/spi_nor_flash_command_sequencer.sv @@
// Top level of the SPI NOR flash command sequencer.
// Instantiates sns_front, sns_job_fifo and sns_back; depends on sns_pkg.
//
// Every request transaction yields one to six result transactions, one per
// SPI byte or event, and the back end delivers one result per clock through
// its output register while the output is not stalled.
// The front end classifies one request per clock against the current flash
// phase and hands a job to a four-entry queue; it stalls only when that queue
// is full. The four-byte address setting is sampled when the request is accepted.
module spi_nor_flash_command_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sns_pkg::ACT_W-1:0]      i_action,
    input  logic [sns_pkg::ADDR_W-1:0]     i_address,
    input  logic [sns_pkg::CNT_W-1:0]      i_byte_count,
    input  logic [sns_pkg::BYTE_W-1:0]     i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sns_pkg::BYTE_W-1:0]     o_spi_byte,
    output logic                           o_spi_valid,
    output logic                           o_cs_release,
    output logic                           o_expect_reply,
    output logic [sns_pkg::BYTE_W-1:0]     o_read_data,
    output logic                           o_read_valid,
    output logic                           o_op_done,
    output logic                           o_phase_error,
    output logic                           o_last
);

    sns_pkg::t_job     front_job;
    sns_pkg::t_job     head_job;
    sns_pkg::t_result  result;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              in_accept;

    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    // request classification
    sns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_action      (i_action),
        .i_address     (i_address),
        .i_byte_count  (i_byte_count),
        .i_value       (i_value),
        .o_job         (front_job)
    );

    // job queue
    sns_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // byte stream generation
    sns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .i_out_stall (i_stall),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_result    (result)
    );

    // result fields
    assign o_spi_byte     = result.spi_byte;
    assign o_spi_valid    = result.spi_valid;
    assign o_cs_release   = result.cs_release;
    assign o_expect_reply = result.expect_reply;
    assign o_read_data    = result.read_data;
    assign o_read_valid   = result.read_valid;
    assign o_op_done      = result.op_done;
    assign o_phase_error  = result.phase_error;
    assign o_last         = result.last;

endmodule

@@ bench/tb_spi_nor_flash_command_sequencer.sv @@
// Self-checking bench for spi_nor_flash_command_sequencer: directed and random flash requests,
// with SPI frames predicted per transaction and compared field by field at the output.
// Depends on sns_pkg and the sequencer RTL only.
module tb_spi_nor_flash_command_sequencer;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int ITEM_TARGET   = 270;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 24;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int LONG_HOLD     = 120;
    localparam int HOLD_AT_A     = 450;
    localparam int HOLD_AT_B     = 1800;
    localparam int PRINT_CAP     = 50;

    // reserved actions, which the block always answers with a phase error
    localparam logic [sns_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [sns_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

    // status register 1 busy bit
    localparam logic [sns_pkg::BYTE_W-1:0] SR1_BUSY = 8'h01;

    // result flag masks
    localparam logic [5:0] F_NONE = 6'b000000;
    localparam logic [5:0] F_SEND = 6'b000001;
    localparam logic [5:0] F_REL  = 6'b000010;
    localparam logic [5:0] F_EXP  = 6'b000100;
    localparam logic [5:0] F_RD   = 6'b001000;
    localparam logic [5:0] F_DONE = 6'b010000;
    localparam logic [5:0] F_ERR  = 6'b100000;

    typedef enum logic {TXN_REQ, TXN_CFG} t_txn_kind;

    typedef struct {
        t_txn_kind                  kind;
        logic [sns_pkg::ACT_W-1:0]  act;
        logic [sns_pkg::ADDR_W-1:0] addr;
        logic [sns_pkg::CNT_W-1:0]  cnt;
        logic [sns_pkg::BYTE_W-1:0] val;
    } t_request;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic                         i_cfg_wr_data = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [sns_pkg::ACT_W-1:0]    i_action = '0;
    logic [sns_pkg::ADDR_W-1:0]   i_address = '0;
    logic [sns_pkg::CNT_W-1:0]    i_byte_count = '0;
    logic [sns_pkg::BYTE_W-1:0]   i_value = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [sns_pkg::BYTE_W-1:0]   o_spi_byte;
    logic                         o_spi_valid;
    logic                         o_cs_release;
    logic                         o_expect_reply;
    logic [sns_pkg::BYTE_W-1:0]   o_read_data;
    logic                         o_read_valid;
    logic                         o_op_done;
    logic                         o_phase_error;
    logic                         o_last;

    spi_nor_flash_command_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_byte_count   (i_byte_count),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_spi_byte     (o_spi_byte),
        .o_spi_valid    (o_spi_valid),
        .o_cs_release   (o_cs_release),
        .o_expect_reply (o_expect_reply),
        .o_read_data    (o_read_data),
        .o_read_valid   (o_read_valid),
        .o_op_done      (o_op_done),
        .o_phase_error  (o_phase_error),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // stimulus and frame bookkeeping
    t_request          request_q[$];
    sns_pkg::t_result  pending_frames[$];
    sns_pkg::t_result  step_frames[$];
    int       legal_count = 0;
    int       mismatch_cnt = 0;
    int       frames_checked = 0;
    int       n_accepted = 0;
    int       n_reads = 0;
    int       n_programs = 0;
    int       n_erases = 0;
    int       n_strays = 0;
    int       cfg_writes = 0;

    // shadow of the sequencer state
    logic                         four_byte_mode = 1'b1;
    sns_pkg::t_phase              ph = sns_pkg::PH_IDLE;
    sns_pkg::t_op                 op = sns_pkg::OP_READ;
    logic [sns_pkg::ADDR_W-1:0]   cur_addr = '0;
    logic [sns_pkg::CNT_W-1:0]    left = '0;
    logic [sns_pkg::PAGE_W:0]     chunk = '0;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // frame building
    task automatic emit(input logic [7:0] spi, input logic [7:0] rd, input logic [5:0] fl);
        sns_pkg::t_result r;
        r.spi_byte     = spi;
        r.spi_valid    = |(fl & F_SEND);
        r.cs_release   = |(fl & F_REL);
        r.expect_reply = |(fl & F_EXP);
        r.read_data    = rd;
        r.read_valid   = |(fl & F_RD);
        r.op_done      = |(fl & F_DONE);
        r.phase_error  = |(fl & F_ERR);
        r.last         = 1'b0;
        step_frames.push_back(r);
    endtask

    task automatic emit_addr(input logic [31:0] a, input logic [5:0] tail_fl);
        if (four_byte_mode)
            emit(a[31:24], 8'h00, F_SEND);
        emit(a[23:16], 8'h00, F_SEND);
        emit(a[15:8], 8'h00, F_SEND);
        emit(a[7:0], 8'h00, F_SEND | tail_fl);
    endtask

    task automatic emit_poll();
        emit(sns_pkg::CMD_RDSR1, 8'h00, F_SEND);
        emit(sns_pkg::DUMMY, 8'h00, F_SEND | F_EXP | F_REL);
    endtask

    task automatic open_page();
        int room;
        room = sns_pkg::PAGE_BYTES - int'(cur_addr[sns_pkg::PAGE_W-1:0]);
        chunk = (int'(left) < room) ? left[sns_pkg::PAGE_W:0] : room[sns_pkg::PAGE_W:0];
        emit(sns_pkg::CMD_WREN, 8'h00, F_SEND | F_REL);
        emit(sns_pkg::CMD_PP, 8'h00, F_SEND);
        emit_addr(cur_addr, F_NONE);
        ph = sns_pkg::PH_WDATA;
    endtask

    // frames caused by one accepted transaction
    task automatic sequence_item(input logic [2:0] act, input logic [31:0] addr,
                                 input logic [15:0] cnt, input logic [7:0] val);
        bit               ok;
        sns_pkg::t_result r;
        ok = 1'b1;
        step_frames.delete();
        case (ph)
            sns_pkg::PH_IDLE: begin
                if (act == sns_pkg::ACT_READ) begin
                    op = sns_pkg::OP_READ;
                    cur_addr = addr;
                    left = cnt;
                    n_reads++;
                    emit(sns_pkg::CMD_READ, 8'h00, F_SEND);
                    if (cnt == 16'd0) begin
                        emit_addr(addr, F_REL | F_DONE);
                    end else begin
                        emit_addr(addr, F_NONE);
                        emit(sns_pkg::DUMMY, 8'h00,
                             F_SEND | F_EXP | ((cnt == 16'd1) ? F_REL : F_NONE));
                        ph = sns_pkg::PH_READ;
                    end
                end else if (act == sns_pkg::ACT_WRITE) begin
                    op = sns_pkg::OP_PROG;
                    cur_addr = addr;
                    left = cnt;
                    n_programs++;
                    if (cnt == 16'd0)
                        emit(8'h00, 8'h00, F_DONE);
                    else
                        open_page();
                end else if (act == sns_pkg::ACT_SECT_ERASE ||
                             act == sns_pkg::ACT_CHIP_ERASE) begin
                    op = (act == sns_pkg::ACT_SECT_ERASE) ? sns_pkg::OP_SECT
                                                          : sns_pkg::OP_CHIP;
                    cur_addr = (act == sns_pkg::ACT_SECT_ERASE)
                               ? (addr << sns_pkg::SECT_SHIFT) : '0;
                    n_erases++;
                    emit(sns_pkg::CMD_WREN, 8'h00, F_SEND | F_REL);
                    emit_poll();
                    ph = sns_pkg::PH_POLL_PRE;
                end else begin
                    ok = 1'b0;
                end
            end
            sns_pkg::PH_READ: begin
                if (act == sns_pkg::ACT_REPLY) begin
                    left = left - 16'd1;
                    if (left == 16'd0) begin
                        emit(8'h00, val, F_RD | F_DONE);
                        ph = sns_pkg::PH_IDLE;
                    end else begin
                        emit(sns_pkg::DUMMY, val, F_RD | F_SEND | F_EXP |
                             ((left == 16'd1) ? F_REL : F_NONE));
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            sns_pkg::PH_WDATA: begin
                if (act == sns_pkg::ACT_WDATA) begin
                    cur_addr = cur_addr + 32'd1;
                    left = left - 16'd1;
                    chunk = chunk - 1'b1;
                    if (chunk == '0) begin
                        emit(val, 8'h00, F_SEND | F_REL);
                        emit_poll();
                        ph = sns_pkg::PH_POLL_PROG;
                    end else begin
                        emit(val, 8'h00, F_SEND);
                    end
                end else begin
                    ok = 1'b0;
                end
            end
            default: begin
                // status polling and erase acknowledge
                if (act != sns_pkg::ACT_REPLY) begin
                    ok = 1'b0;
                end else if (ph == sns_pkg::PH_ERASE_ACK) begin
                    emit_poll();
                    ph = sns_pkg::PH_POLL_POST;
                end else if ((val & SR1_BUSY) != 8'h00) begin
                    emit_poll();
                end else if (ph == sns_pkg::PH_POLL_PROG) begin
                    if (left != 16'd0) begin
                        open_page();
                    end else begin
                        emit(8'h00, 8'h00, F_DONE);
                        ph = sns_pkg::PH_IDLE;
                    end
                end else if (ph == sns_pkg::PH_POLL_PRE) begin
                    if (op == sns_pkg::OP_CHIP) begin
                        emit(sns_pkg::CMD_CE, 8'h00, F_SEND | F_REL);
                        emit_poll();
                        ph = sns_pkg::PH_POLL_POST;
                    end else begin
                        emit(sns_pkg::CMD_SE, 8'h00, F_SEND);
                        emit_addr(cur_addr, F_REL | F_EXP);
                        ph = sns_pkg::PH_ERASE_ACK;
                    end
                end else begin
                    emit(8'h00, 8'h00, F_DONE);
                    ph = sns_pkg::PH_IDLE;
                end
            end
        endcase
        if (!ok) begin
            n_strays++;
            emit(8'h00, 8'h00, F_ERR);
        end
        r = step_frames.pop_back();
        r.last = 1'b1;
        step_frames.push_back(r);
        foreach (step_frames[i])
            pending_frames.push_back(step_frames[i]);
    endtask

    // stimulus building
    task automatic add_txn(input logic [2:0] act, input logic [31:0] a, input logic [15:0] n,
                           input logic [7:0] v, input bit legal);
        t_request s;
        s.kind = TXN_REQ;
        s.act  = act;
        s.addr = a;
        s.cnt  = n;
        s.val  = v;
        request_q.push_back(s);
        if (legal)
            legal_count++;
    endtask

    task automatic add_cfg(input logic v);
        t_request s;
        s.kind = TXN_CFG;
        s.act  = sns_pkg::ACT_READ;
        s.addr = '0;
        s.cnt  = '0;
        s.val  = {7'd0, v};
        request_q.push_back(s);
    endtask

    // out-of-phase transaction with random content
    task automatic add_stray(input bit at_idle, input logic [2:0] good);
        logic [2:0] act;
        bit         legal_here;
        do begin
            act = 3'($urandom_range(7));
            legal_here = at_idle ? (act == sns_pkg::ACT_READ || act == sns_pkg::ACT_WRITE ||
                                    act == sns_pkg::ACT_SECT_ERASE ||
                                    act == sns_pkg::ACT_CHIP_ERASE)
                                 : (act == good);
        end while (legal_here);
        add_txn(act, $urandom, 16'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic maybe_stray(input bit at_idle, input logic [2:0] good);
        if ($urandom_range(99) < 6)
            add_stray(at_idle, good);
    endtask

    task automatic add_reply(input logic [7:0] v);
        maybe_stray(1'b0, sns_pkg::ACT_REPLY);
        add_txn(sns_pkg::ACT_REPLY, $urandom, 16'($urandom), v, 1'b1);
    endtask

    task automatic poll_until_ready(input int busy);
        repeat (busy)
            add_reply(8'($urandom) | SR1_BUSY);
        add_reply(8'($urandom) & ~SR1_BUSY);
    endtask

    task automatic gen_read(input logic [31:0] a, input int n);
        maybe_stray(1'b1, sns_pkg::ACT_READ);
        add_txn(sns_pkg::ACT_READ, a, 16'(n), 8'($urandom), 1'b1);
        repeat (n)
            add_reply(8'($urandom));
    endtask

    // program split at page boundaries, each page followed by a status poll
    task automatic gen_program(input logic [31:0] a, input int n);
        logic [31:0] at;
        int          rest;
        int          room;
        int          part;
        maybe_stray(1'b1, sns_pkg::ACT_WRITE);
        add_txn(sns_pkg::ACT_WRITE, a, 16'(n), 8'($urandom), 1'b1);
        at = a;
        rest = n;
        while (rest > 0) begin
            room = sns_pkg::PAGE_BYTES - int'(at[sns_pkg::PAGE_W-1:0]);
            part = (rest < room) ? rest : room;
            repeat (part) begin
                maybe_stray(1'b0, sns_pkg::ACT_WDATA);
                add_txn(sns_pkg::ACT_WDATA, $urandom, 16'($urandom), 8'($urandom), 1'b1);
            end
            at = at + 32'(part);
            rest = rest - part;
            poll_until_ready($urandom_range(0, 2));
        end
    endtask

    task automatic gen_erase(input bit whole_chip, input logic [31:0] idx);
        maybe_stray(1'b1, sns_pkg::ACT_SECT_ERASE);
        add_txn(whole_chip ? sns_pkg::ACT_CHIP_ERASE : sns_pkg::ACT_SECT_ERASE, idx,
                16'($urandom), 8'($urandom), 1'b1);
        poll_until_ready($urandom_range(0, 2));
        if (!whole_chip)
            add_reply(8'($urandom));
        poll_until_ready($urandom_range(0, 2));
    endtask

    task automatic random_ops(input int upto);
        int          pick;
        int          n;
        logic [31:0] a;
        while (legal_count < upto) begin
            pick = $urandom_range(19);
            a = $urandom;
            if (pick < 7) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
                gen_read(a, n);
            end else if (pick < 14) begin
                if ($urandom_range(2) == 0)
                    a[7:0] = 8'($urandom_range(240, 255));
                n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
                gen_program(a, n);
            end else if (pick < 17) begin
                gen_erase(1'b0, a);
            end else if (pick < 19) begin
                gen_erase(1'b1, a);
            end else begin
                add_stray(1'b1, sns_pkg::ACT_READ);
            end
        end
    endtask

    // driver: bursts with random gaps, waits for idle before register writes
    int gap_left = 0;
    int burst_left = 0;
    int settle_cnt = 0;

    always @(posedge i_clk) begin
        bit       took;
        bit       offer;
        bit       cfg_go;
        t_request nxt;
        took = 1'b0;
        offer = 1'b0;
        cfg_go = 1'b0;
        if (i_rst_n) begin
            took = i_valid && !o_stall;
            if (took) begin
                n_accepted++;
                sequence_item(i_action, i_address, i_byte_count, i_value);
            end
            if (i_valid && !took) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() > 0) begin
                if (request_q[0].kind == TXN_REQ) begin
                    nxt = request_q.pop_front();
                    offer = 1'b1;
                    i_action <= nxt.act;
                    i_address <= nxt.addr;
                    i_byte_count <= nxt.cnt;
                    i_value <= nxt.val;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        gap_left = $urandom_range(1, 8);
                        burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60)
                                                               : $urandom_range(1, 8);
                    end
                end else if (took || pending_frames.size() != 0) begin
                    settle_cnt = 0;
                end else if (settle_cnt < SETTLE_CYCLES) begin
                    settle_cnt++;
                end else begin
                    nxt = request_q.pop_front();
                    settle_cnt = 0;
                    cfg_go = 1'b1;
                    i_cfg_wr_data <= nxt.val[0];
                    four_byte_mode = nxt.val[0];
                    cfg_writes++;
                end
            end
        end
        i_valid <= offer;
        i_cfg_wr_en <= cfg_go;
    end

    // output stall pattern with two long hold-offs
    int cycle_cnt = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            cycle_cnt++;
            if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B)
                hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 48);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end else begin
                    seg_left--;
                end
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // monitor: compare each output transaction with the oldest predicted frame
    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %02h, expected %02h (frame %0d)",
                                      name, got, want, frames_checked));
    endtask

    always @(posedge i_clk) begin
        sns_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("output transaction with no frame pending");
            end else begin
                want = pending_frames.pop_front();
                check_field("spi_byte", o_spi_byte, want.spi_byte);
                check_field("spi_valid", {7'd0, o_spi_valid}, {7'd0, want.spi_valid});
                check_field("cs_release", {7'd0, o_cs_release}, {7'd0, want.cs_release});
                check_field("expect_reply", {7'd0, o_expect_reply}, {7'd0, want.expect_reply});
                check_field("read_data", o_read_data, want.read_data);
                check_field("read_valid", {7'd0, o_read_valid}, {7'd0, want.read_valid});
                check_field("op_done", {7'd0, o_op_done}, {7'd0, want.op_done});
                check_field("phase_error", {7'd0, o_phase_error}, {7'd0, want.phase_error});
                check_field("last", {7'd0, o_last}, {7'd0, want.last});
                frames_checked++;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // out-of-phase actions while idle, reserved codes with all-ones and alternating-bit fields
        add_txn(sns_pkg::ACT_WDATA, 32'h0000_0000, 16'h0000, 8'h00, 1'b0);
        add_txn(sns_pkg::ACT_REPLY, 32'h5555_5555, 16'h5555, 8'h55, 1'b0);
        add_txn(ACT_RSVD6, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0);
        add_txn(ACT_RSVD7, 32'hAAAA_AAAA, 16'hAAAA, 8'hAA, 1'b0);
        // zero length read at the top address, then one-byte read
        add_txn(sns_pkg::ACT_READ, 32'hFFFF_FFFF, 16'd0, 8'h00, 1'b1);
        add_txn(sns_pkg::ACT_READ, 32'h0000_0000, 16'd1, 8'h00, 1'b1);
        add_reply(8'hA5);
        // two-byte read with a stray request in the middle
        add_txn(sns_pkg::ACT_READ, 32'h1234_5678, 16'd2, 8'h00, 1'b1);
        add_txn(sns_pkg::ACT_WRITE, 32'h0000_0100, 16'd4, 8'h00, 1'b0);
        add_reply(8'h00);
        add_reply(8'hFF);
        // zero length program, then a program that wraps the address space
        add_txn(sns_pkg::ACT_WRITE, 32'h0000_00FF, 16'd0, 8'h00, 1'b1);
        gen_program(32'hFFFF_FFFE, 3);
        // sector erase whose byte address wraps, acknowledge with busy bit set
        add_txn(sns_pkg::ACT_SECT_ERASE, 32'hFFFF_FFFF, 16'd0, 8'h00, 1'b1);
        add_reply(8'h00);
        add_reply(8'hFF);
        add_reply(8'h01);
        add_reply(8'hFE);
        gen_erase(1'b1, 32'h0);

        // random part over both address widths
        add_cfg(1'b0);
        random_ops(120);
        add_cfg(1'b1);
        random_ops(200);
        add_cfg(1'b0);
        random_ops(ITEM_TARGET);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (request_q.size() != 0 || i_valid || pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d reads, %0d programs, %0d erases, %0d out of phase",
                 n_accepted, n_reads, n_programs, n_erases, n_strays);
        $display("checked %0d frames over %0d address width changes, longest hold-off %0d cycles",
                 frames_checked, cfg_writes, LONG_HOLD);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("run limit reached with %0d frames still pending", pending_frames.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ spi_nor_flash_command_sequencer.f @@
rtl/sns_pkg.sv
rtl/sns_front.sv
rtl/sns_job_fifo.sv
rtl/sns_back.sv
rtl/spi_nor_flash_command_sequencer.sv
bench/tb_spi_nor_flash_command_sequencer.sv
